// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// Types, character codes and helpers of the packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // Upper bound of the frame size limit, in bytes.
  localparam int unsigned FRAME_LIMIT = 16384;
  localparam int unsigned LEN_W       = 15;

  typedef logic [LEN_W-1:0] len_t;

  localparam len_t LIMIT_MAX = LEN_W'(FRAME_LIMIT);
  localparam len_t LIMIT_MIN = LEN_W'(4);

  // Framing and acknowledge characters.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    PH_START,
    PH_PAYLOAD,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_BADHEX   = 3'd2,
    ST_NOSTART  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // One result word of the deframer.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    status_t    status;
    len_t       payload_len;
    logic [7:0] computed_sum;
    logic [7:0] ack_char;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit; a byte outside 0-9, a-f, A-F is flagged bad.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = 4'(c[3:0] + 4'd9);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

// ===== rtl/rsp_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// Deframes $payload#hh packets from a byte stream and reports frame status.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle and keeps that rate for as long
// as the output side takes words. A byte is caught in an input register at the
// edge that accepts it. The frame logic then works on it and loads the result
// into an output register once it is free, and the result word is offered
// from there. The frame logic updates its count and sum as the byte leaves
// the input register. Payload bytes come out as words with out_tuser low. The
// end of a frame (after the two checksum digits, or on overflow) comes out as
// one word with out_tuser high that carries status, payload length, payload
// sum and the ack character to send back. The start byte, '#' and the first
// checksum digit give no word. Write cfg_wdata only while no byte is in
// flight; the limit is clamped to the range 4 to 16384 bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsp_packet_deframer import rpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: max_frame_len.
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  // Received bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] data_byte, [10:8] status,
                                  // [25:11] payload_len, [33:26] computed_sum,
                                  // [41:34] ack_char, [47:42] zero
  output logic [0:0]  out_tuser   // [0] kind
);

  len_t       max_len_r;
  len_t       limit;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       in_fire;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LIMIT_MAX;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // Clamp the limit into its legal range.
  always_comb begin
    priority if (max_len_r > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else if (max_len_r < LIMIT_MIN) begin
      limit = LIMIT_MIN;
    end else begin
      limit = max_len_r;
    end
  end

  // Handshake: the input register advances when the output register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && res_valid) || (out_valid_r && !out_tready);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Frame logic.
  rpd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .rx_byte   (s1_byte_r),
    .limit     (limit),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.ack_char, out_res_r.computed_sum,
                       out_res_r.payload_len, out_res_r.status, out_res_r.data_byte};

  // Payload words carry no status and no ack character.
  `ASSERT_ALWAYS(a_payload_word_clean, clk, rst_n,
    out_valid_r && !out_res_r.kind |-> out_res_r.status == ST_OK &&
      out_res_r.ack_char == 8'd0 && out_res_r.payload_len == '0,
    "payload word carries frame-end fields")

  // The ack character agrees with the frame status.
  `ASSERT_ALWAYS(a_ack_matches_status, clk, rst_n,
    out_valid_r && out_res_r.kind |->
      (out_res_r.status == ST_OK && out_res_r.ack_char == CH_ACK) ||
      (out_res_r.status != ST_OK && out_res_r.ack_char == CH_NAK),
    "ack character disagrees with status")

  // A frame never reports a payload length as large as the largest limit.
  `ASSERT_NEVER(a_len_in_range, clk, rst_n,
    out_valid_r && out_res_r.kind && out_res_r.payload_len >= LIMIT_MAX,
    "payload length beyond frame limit")

  // A byte held in the input register is not lost while the output stalls.
  `ASSERT_ALWAYS(a_input_held, clk, rst_n,
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r),
    "stalled input byte changed")

endmodule

// ===== rtl/rpd_frame.sv =====
// ----------------------------------------------------------------------------
// rpd_frame
// Frame state machine: tracks phase, byte count, payload sum and digit
// checks, and forms at most one result word per input byte.
// ----------------------------------------------------------------------------
module rpd_frame import rpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,       // process rx_byte this cycle
  input  logic [7:0] rx_byte,
  input  len_t       limit,      // clamped frame size limit
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  len_t       count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] high_r, high_nxt;
  logic       start_bad_r, start_bad_nxt;
  logic       digit_bad_r, digit_bad_nxt;

  hex_t          hex_b;
  logic [LEN_W:0] count_inc;
  len_t          payload_cnt;
  logic [7:0]    sum_add;
  logic [7:0]    given;
  logic          digit_bad_all;
  status_t       end_status;

  // Shared terms of the per-byte update.
  always_comb begin
    hex_b         = hex_decode(rx_byte);
    count_inc     = {1'b0, count_r} + 1'b1;
    payload_cnt   = (count_r != '0) ? len_t'(count_r - 1'b1) : '0;
    sum_add       = 8'(sum_r + rx_byte);
    given         = {high_r, hex_b.value};
    digit_bad_all = digit_bad_r | hex_b.bad;
    priority if (start_bad_r) begin
      end_status = ST_NOSTART;
    end else if (digit_bad_all) begin
      end_status = ST_BADHEX;
    end else if (given != sum_r) begin
      end_status = ST_MISMATCH;
    end else begin
      end_status = ST_OK;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    high_nxt      = high_r;
    start_bad_nxt = start_bad_r;
    digit_bad_nxt = digit_bad_r;
    unique case (phase_r)
      PH_START: begin
        sum_nxt       = 8'd0;
        high_nxt      = 4'd0;
        digit_bad_nxt = 1'b0;
        start_bad_nxt = (rx_byte != CH_START);
        if (rx_byte == CH_END) begin
          count_nxt = '0;
          phase_nxt = PH_HIGH;
        end else begin
          count_nxt = LEN_W'(1);
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_END) begin
          phase_nxt = PH_HIGH;
        end else if (count_inc >= {1'b0, limit}) begin
          phase_nxt = PH_START;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc[LEN_W-1:0];
          sum_nxt   = sum_add;
        end
      end
      PH_HIGH: begin
        high_nxt      = hex_b.value;
        digit_bad_nxt = digit_bad_all;
        phase_nxt     = PH_LOW;
      end
      PH_LOW: begin
        digit_bad_nxt = digit_bad_all;
        phase_nxt     = PH_START;
        count_nxt     = '0;
      end
      default: phase_nxt = PH_START;
    endcase
  end

  // Result word.
  always_comb begin
    res_valid = 1'b0;
    res       = '{kind: 1'b0, data_byte: 8'd0, status: ST_OK, payload_len: '0,
                  computed_sum: sum_r, ack_char: 8'd0};
    unique case (phase_r)
      PH_PAYLOAD: begin
        if (rx_byte != CH_END) begin
          res_valid = 1'b1;
          if (count_inc >= {1'b0, limit}) begin
            res.kind        = 1'b1;
            res.status      = ST_OVERFLOW;
            res.payload_len = payload_cnt;
            res.ack_char    = CH_NAK;
          end else begin
            res.data_byte    = rx_byte;
            res.computed_sum = sum_add;
          end
        end
      end
      PH_LOW: begin
        res_valid       = 1'b1;
        res.kind        = 1'b1;
        res.status      = end_status;
        res.payload_len = payload_cnt;
        res.ack_char    = (end_status == ST_OK) ? CH_ACK : CH_NAK;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      count_r     <= '0;
      sum_r       <= 8'd0;
      high_r      <= 4'd0;
      start_bad_r <= 1'b0;
      digit_bad_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      high_r      <= high_nxt;
      start_bad_r <= start_bad_nxt;
      digit_bad_r <= digit_bad_nxt;
    end
  end

endmodule
